// ===== rtl/core/rgbwle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rgbwle_pkg;

	typedef logic [2:0]  mode_t;
	typedef logic [2:0]  reg_idx_t;
	typedef logic [23:0] rgb_t;
	typedef logic [10:0] wheel_t;

	localparam mode_t MODE_STATIC = 3'd0;
	localparam mode_t MODE_WHEEL  = 3'd1;
	localparam mode_t MODE_PASTEL = 3'd2;
	localparam mode_t MODE_HUE    = 3'd3;
	localparam mode_t MODE_STROBE = 3'd4;

	localparam reg_idx_t REG_EFFECT_MODE  = 3'd0;
	localparam reg_idx_t REG_STEP_SIZE    = 3'd1;
	localparam reg_idx_t REG_BRIGHTNESS   = 3'd2;
	localparam reg_idx_t REG_WHITE_LEVEL  = 3'd3;
	localparam reg_idx_t REG_STATIC_COLOR = 3'd4;

	localparam wheel_t     WHEEL_MAX  = 11'd1530;
	localparam logic [7:0] HUE_REGION = 8'd43;
	localparam logic [7:0] PASTEL_SAT = 8'd125;
	localparam logic [7:0] FULL_SAT   = 8'd255;

	localparam rgb_t       RESET_COLOR  = 24'h00781E;
	localparam logic [7:0] RESET_HUE    = 8'd100;
	localparam wheel_t     RESET_WHEEL  = 11'd1;
	localparam logic [7:0] RESET_STEP   = 8'd1;
	localparam logic [7:0] RESET_BRIGHT = 8'd255;

	// (255 * x) >> 8 for an 8-bit x
	function automatic logic [7:0] times255_hi(input logic [7:0] x);
		return (x == 8'd0) ? 8'd0 : x - 8'd1;
	endfunction

	// floor(p / 255) for p up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] s;
		s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
		return s[15:8];
	endfunction

	function automatic rgb_t wheel_color(input wheel_t pos);
		wheel_t d;
		rgb_t   c;
		if (pos <= 11'd255) begin
			c = {8'd255, pos[7:0], 8'd0};
		end else if (pos <= 11'd510) begin
			d = 11'd510 - pos;
			c = {d[7:0], 8'd255, 8'd0};
		end else if (pos <= 11'd765) begin
			d = pos - 11'd510;
			c = {8'd0, 8'd255, d[7:0]};
		end else if (pos <= 11'd1020) begin
			d = 11'd1020 - pos;
			c = {8'd0, d[7:0], 8'd255};
		end else if (pos <= 11'd1275) begin
			d = pos - 11'd1020;
			c = {d[7:0], 8'd0, 8'd255};
		end else if (pos <= WHEEL_MAX) begin
			d = WHEEL_MAX - pos;
			c = {8'd255, 8'd0, d[7:0]};
		end else begin
			c = {8'd255, 8'd0, 8'd0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgbw_led_effect_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake            | payload
// in      | in_valid / in_ready  | advance
// out     | out_valid / out_ready| duty_red, duty_green, duty_blue, duty_white
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// an item runs S_TICK, S_COLOR, S_SCALE, S_OUT, and S_MULQ, S_MULT, S_PACK when a hue mode advances:
// one shared 8x8 multiplier does the two hsv products and the four duty scalings
// in turn, the duty products go through it back to back, one a cycle
// in_ready is low from acceptance until the result is loaded into the output register
// a waiting result does not block the next item, only its final load
// arst_n clears effect state, config registers and the sequencer at once
module rgbw_led_effect_engine (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire                        advance,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [7:0]                 duty_red,
	output logic [7:0]                 duty_green,
	output logic [7:0]                 duty_blue,
	output logic [7:0]                 duty_white,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire rgbwle_pkg::reg_idx_t  cfg_index,
	input  wire [23:0]                 cfg_data
);
	import rgbwle_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TICK  = 3'd1;
	localparam logic [2:0] S_COLOR = 3'd2;
	localparam logic [2:0] S_MULQ  = 3'd3;
	localparam logic [2:0] S_MULT  = 3'd4;
	localparam logic [2:0] S_PACK  = 3'd5;
	localparam logic [2:0] S_SCALE = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0]  state_q;
	logic        adv_q;
	logic [2:0]  cnt_q;

	mode_t       mode_q;
	logic [7:0]  step_q;
	logic [7:0]  bright_q;
	logic [7:0]  white_q;
	rgb_t        static_q;

	logic [7:0]  hue_q;
	wheel_t      wheel_q;
	logic        dir_q;
	logic        strobe_q;
	rgb_t        color_q;

	logic [15:0] prod_q;
	logic [7:0]  qv_q;
	logic [7:0]  res_q [4];

	// tick next values
	logic [11:0]        wsum;
	logic [11:0]        wdiff;
	wheel_t             wheel_n;
	logic               wdir_n;
	logic signed [10:0] hup;
	logic signed [10:0] hdn;
	logic signed [10:0] hup2;
	logic signed [10:0] hdn2;
	logic [7:0]         phue_n;
	logic               pdir_n;
	logic [7:0]         fhue_n;
	logic               fdir_n;

	// hsv
	logic [2:0]  region;
	logic [7:0]  base;
	logic [7:0]  diff;
	logic [7:0]  rem;
	logic [7:0]  sat;
	logic [7:0]  pv;
	logic [7:0]  tv;
	rgb_t        hsv_rgb;

	// shared multiplier and duty path
	logic [7:0]  mul_a;
	logic [7:0]  mul_b;
	logic [15:0] mul_p;
	rgb_t        disp_color;
	logic [7:0]  eff_bright;
	logic [1:0]  wr_idx;

	always_comb begin
		wsum  = {1'b0, wheel_q} + {4'd0, step_q};
		wdiff = {1'b0, wheel_q} - {4'd0, step_q};
		wheel_n = wheel_q;
		wdir_n  = dir_q;
		if (dir_q) begin
			if (wsum > {1'b0, WHEEL_MAX}) begin
				wheel_n = WHEEL_MAX;
				wdir_n  = 1'b0;
			end else begin
				wheel_n = wsum[10:0];
			end
		end else begin
			if ({3'd0, step_q} > wheel_q) begin
				wheel_n = '0;
				wdir_n  = 1'b1;
			end else begin
				wheel_n = wdiff[10:0];
			end
		end

		hup  = $signed({3'd0, hue_q}) + $signed({3'd0, step_q});
		hdn  = $signed({3'd0, hue_q}) - $signed({3'd0, step_q});
		hup2 = hup + $signed({3'd0, step_q});
		hdn2 = hdn - $signed({3'd0, step_q});

		pdir_n = dir_q;
		if (dir_q) begin
			phue_n = (hdn < 11'sd0) ? 8'd0 : hdn[7:0];
			if (hdn2 <= 11'sd0) begin
				pdir_n = 1'b0;
			end
		end else begin
			phue_n = (hup > 11'sd255) ? 8'd255 : hup[7:0];
			if (hup2 >= 11'sd255) begin
				pdir_n = 1'b1;
			end
		end

		fdir_n = dir_q;
		if (dir_q) begin
			if (hup > 11'sd255) begin
				fhue_n = 8'd255;
				fdir_n = 1'b0;
			end else begin
				fhue_n = hup[7:0];
			end
		end else begin
			if (hdn < 11'sd0) begin
				fhue_n = 8'd0;
				fdir_n = 1'b1;
			end else begin
				fhue_n = hdn[7:0];
			end
		end
	end

	always_comb begin
		if (hue_q >= 8'd215) begin
			region = 3'd5;
		end else if (hue_q >= 8'd172) begin
			region = 3'd4;
		end else if (hue_q >= 8'd129) begin
			region = 3'd3;
		end else if (hue_q >= 8'd86) begin
			region = 3'd2;
		end else if (hue_q >= HUE_REGION) begin
			region = 3'd1;
		end else begin
			region = 3'd0;
		end
		case (region)
			3'd1:    base = HUE_REGION;
			3'd2:    base = 8'd86;
			3'd3:    base = 8'd129;
			3'd4:    base = 8'd172;
			3'd5:    base = 8'd215;
			default: base = 8'd0;
		endcase
		diff = hue_q - base;
		rem  = {diff[5:0], 2'b00} + {diff[6:0], 1'b0};
		sat  = (mode_q == MODE_PASTEL) ? PASTEL_SAT : FULL_SAT;
		pv   = times255_hi(8'd255 - sat);
		tv   = times255_hi(8'd255 - prod_q[15:8]);
		unique case (region)
			3'd0:    hsv_rgb = {8'd255, tv, pv};
			3'd1:    hsv_rgb = {qv_q, 8'd255, pv};
			3'd2:    hsv_rgb = {pv, 8'd255, tv};
			3'd3:    hsv_rgb = {pv, qv_q, 8'd255};
			3'd4:    hsv_rgb = {tv, pv, 8'd255};
			default: hsv_rgb = {8'd255, pv, qv_q};
		endcase
	end

	always_comb begin
		disp_color = (mode_q == MODE_STATIC) ? static_q : color_q;
		eff_bright = (mode_q == MODE_STROBE && !strobe_q) ? 8'd0 : bright_q;
		wr_idx     = cnt_q[1:0] - 2'd1;
		mul_a      = sat;
		mul_b      = rem;
		if (state_q == S_MULT) begin
			mul_b = 8'd255 - rem;
		end else if (state_q == S_SCALE) begin
			mul_b = eff_bright;
			case (cnt_q[1:0])
				2'd0:    mul_a = disp_color[23:16];
				2'd1:    mul_a = disp_color[15:8];
				2'd2:    mul_a = disp_color[7:0];
				default: mul_a = white_q;
			endcase
		end
		mul_p = mul_a * mul_b;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_STATIC;
			step_q   <= RESET_STEP;
			bright_q <= RESET_BRIGHT;
			white_q  <= '0;
			static_q <= RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EFFECT_MODE:  mode_q   <= cfg_data[2:0];
				REG_STEP_SIZE:    step_q   <= cfg_data[7:0];
				REG_BRIGHTNESS:   bright_q <= cfg_data[7:0];
				REG_WHITE_LEVEL:  white_q  <= cfg_data[7:0];
				REG_STATIC_COLOR: static_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			adv_q     <= 1'b0;
			cnt_q     <= '0;
			hue_q     <= RESET_HUE;
			wheel_q   <= RESET_WHEEL;
			dir_q     <= 1'b1;
			strobe_q  <= 1'b1;
			color_q   <= RESET_COLOR;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						adv_q   <= advance;
						state_q <= S_TICK;
					end
				end
				S_TICK: begin
					if (adv_q) begin
						case (mode_q)
							MODE_STATIC: color_q <= static_q;
							MODE_WHEEL: begin
								wheel_q <= wheel_n;
								dir_q   <= wdir_n;
							end
							MODE_PASTEL: begin
								hue_q <= phue_n;
								dir_q <= pdir_n;
							end
							MODE_HUE: begin
								hue_q <= fhue_n;
								dir_q <= fdir_n;
							end
							MODE_STROBE: strobe_q <= ~strobe_q;
							default: ;
						endcase
					end
					state_q <= S_COLOR;
				end
				S_COLOR: begin
					cnt_q <= '0;
					if (adv_q) begin
						case (mode_q) inside
							MODE_WHEEL: begin
								color_q <= wheel_color(wheel_q);
								state_q <= S_SCALE;
							end
							MODE_PASTEL, MODE_HUE: state_q <= S_MULQ;
							default: state_q <= S_SCALE;
						endcase
					end else begin
						state_q <= S_SCALE;
					end
				end
				S_MULQ: begin
					state_q <= S_MULT;
				end
				S_MULT: begin
					state_q <= S_PACK;
				end
				S_PACK: begin
					color_q <= hsv_rgb;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MULQ || state_q == S_MULT || state_q == S_SCALE) begin
			prod_q <= mul_p;
		end
		if (state_q == S_MULT) begin
			qv_q <= times255_hi(8'd255 - prod_q[15:8]);
		end
		if (state_q == S_SCALE && cnt_q != 3'd0) begin
			res_q[wr_idx] <= div255(prod_q);
		end
		if (state_q == S_OUT && (!out_valid || out_ready)) begin
			duty_red   <= res_q[0];
			duty_green <= res_q[1];
			duty_blue  <= res_q[2];
			duty_white <= res_q[3];
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted item did not make the engine busy");

	a_wheel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wheel_q <= WHEEL_MAX)
		else $error("wheel position beyond end of wheel");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result shown without finishing the sequence");
`endif

endmodule

`default_nettype wire

// ===== sim/rgbw_led_effect_engine_tb.sv =====
`timescale 1ns / 1ps

module rgbw_led_effect_engine_tb;
	import rgbwle_pkg::*;

	localparam mode_t    MODE_SPARE = 3'd7;
	localparam reg_idx_t REG_SPARE  = 3'd5;
	localparam int       RAND_ITEMS = 600;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] white;
	} duty_t;

	class duty_scoreboard;
		mode_t      eff_mode;
		logic [7:0] stride;
		logic [7:0] gain;
		logic [7:0] white;
		rgb_t       solid_rgb;
		logic [7:0] hue;
		wheel_t     wheel_pos;
		bit         rising;
		bit         strobe_on;
		rgb_t       live_rgb;
		duty_t      pending_duties[$];
		int         errors;

		function new();
			eff_mode  = MODE_STATIC;
			stride    = RESET_STEP;
			gain      = RESET_BRIGHT;
			white     = 8'd0;
			solid_rgb = RESET_COLOR;
			hue       = RESET_HUE;
			wheel_pos = RESET_WHEEL;
			rising    = 1'b1;
			strobe_on = 1'b1;
			live_rgb  = RESET_COLOR;
			errors    = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [23:0] data);
			case (idx)
				REG_EFFECT_MODE:  eff_mode = data[2:0];
				REG_STEP_SIZE:    stride = data[7:0];
				REG_BRIGHTNESS:   gain = data[7:0];
				REG_WHITE_LEVEL:  white = data[7:0];
				REG_STATIC_COLOR: solid_rgb = data;
				default: ;
			endcase
		endfunction

		function rgb_t pack(int r, int g, int b);
			return {r[7:0], g[7:0], b[7:0]};
		endfunction

		function rgb_t wheel_rgb(int p);
			if (p <= 255) return pack(255, p, 0);
			if (p <= 510) return pack(510 - p, 255, 0);
			if (p <= 765) return pack(0, 255, p - 510);
			if (p <= 1020) return pack(0, 1020 - p, 255);
			if (p <= 1275) return pack(p - 1020, 0, 255);
			if (p <= 1530) return pack(255, 0, 1530 - p);
			return pack(255, 0, 0);
		endfunction

		function rgb_t hsv_rgb(int h, int s);
			int region;
			int rem;
			int p;
			int q;
			int t;
			region = h / 43;
			rem = ((h - region * 43) * 6) & 255;
			p = (255 * (255 - s)) >> 8;
			q = (255 * (255 - ((s * rem) >> 8))) >> 8;
			t = (255 * (255 - ((s * (255 - rem)) >> 8))) >> 8;
			case (region)
				0: return pack(255, t, p);
				1: return pack(q, 255, p);
				2: return pack(p, 255, t);
				3: return pack(p, q, 255);
				4: return pack(t, p, 255);
				default: return pack(255, p, q);
			endcase
		endfunction

		function logic [7:0] scale(int c, int b);
			int p;
			p = (c * b) / 255;
			return p[7:0];
		endfunction

		function void step_effect();
			int h;
			int st;
			int w;
			h = hue;
			st = stride;
			case (eff_mode)
				MODE_STATIC: live_rgb = solid_rgb;
				MODE_WHEEL: begin
					w = wheel_pos;
					w = rising ? w + st : w - st;
					if (w < 0) begin
						w = 0;
						rising = 1'b1;
					end else if (w > 1530) begin
						w = 1530;
						rising = 1'b0;
					end
					wheel_pos = w[10:0];
					live_rgb = wheel_rgb(w);
				end
				MODE_PASTEL: begin
					if (rising) begin
						h = h - st;
						if (h - st <= 0) rising = 1'b0;
					end else begin
						h = h + st;
						if (h + st >= 255) rising = 1'b1;
					end
					if (h < 0) h = 0;
					if (h > 255) h = 255;
					hue = h[7:0];
					live_rgb = hsv_rgb(h, PASTEL_SAT);
				end
				MODE_HUE: begin
					h = rising ? h + st : h - st;
					if (h < 0) begin
						h = 0;
						rising = 1'b1;
					end else if (h > 255) begin
						h = 255;
						rising = 1'b0;
					end
					hue = h[7:0];
					live_rgb = hsv_rgb(h, FULL_SAT);
				end
				MODE_STROBE: strobe_on = !strobe_on;
				default: ;
			endcase
		endfunction

		function void note_item(bit adv);
			rgb_t  c;
			int    b;
			duty_t d;
			if (adv) step_effect();
			c = (eff_mode == MODE_STATIC) ? solid_rgb : live_rgb;
			b = gain;
			if (eff_mode == MODE_STROBE && !strobe_on) b = 0;
			d.red   = scale(c[23:16], b);
			d.green = scale(c[15:8], b);
			d.blue  = scale(c[7:0], b);
			d.white = scale(white, b);
			pending_duties.push_back(d);
		endfunction

		function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
			if (got_v !== exp_v) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_item(duty_t got);
			duty_t exp_d;
			if (pending_duties.size() == 0) begin
				$display("%0t: unexpected item, got %h", $time, got);
				errors++;
				return;
			end
			exp_d = pending_duties.pop_front();
			compare_field("duty_red", exp_d.red, got.red);
			compare_field("duty_green", exp_d.green, got.green);
			compare_field("duty_blue", exp_d.blue, got.blue);
			compare_field("duty_white", exp_d.white, got.white);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       advance = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] duty_red;
	logic [7:0] duty_green;
	logic [7:0] duty_blue;
	logic [7:0] duty_white;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	reg_idx_t   cfg_index = REG_EFFECT_MODE;
	logic [23:0] cfg_data = 24'd0;
	bit         calm = 1'b0;

	duty_scoreboard sb = new();

	rgbw_led_effect_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.duty_red   (duty_red),
		.duty_green (duty_green),
		.duty_blue  (duty_blue),
		.duty_white (duty_white),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL rgbw_led_effect_engine");
		$finish;
	end

	always @(negedge clk) begin
		out_ready = calm || ($urandom_range(0, 99) >= 33);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_item({duty_red, duty_green, duty_blue, duty_white});
	end

	task automatic send_tick(input bit adv);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 33) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		advance = adv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(adv);
	endtask

	// hold off until every item has come back and the pipeline is empty
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_duties.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_setting(input reg_idx_t idx, input logic [23:0] data);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 4))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(1, 8));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_settings();
		logic [23:0] data;
		mode_t       m;
		if ($urandom_range(0, 9) < 7) begin
			if ($urandom_range(0, 9) == 0)
				m = mode_t'($urandom_range(5, 7));
			else
				m = mode_t'($urandom_range(0, 4));
			data = 24'($urandom);
			data[2:0] = m;
			write_setting(REG_EFFECT_MODE, data);
		end
		if ($urandom_range(0, 1)) begin
			data = 24'($urandom);
			data[7:0] = pick_byte();
			write_setting(REG_STEP_SIZE, data);
		end
		if ($urandom_range(0, 2) == 0) begin
			data = 24'($urandom);
			data[7:0] = pick_byte();
			write_setting(REG_BRIGHTNESS, data);
		end
		if ($urandom_range(0, 2) == 0) begin
			data = 24'($urandom);
			data[7:0] = pick_byte();
			write_setting(REG_WHITE_LEVEL, data);
		end
		if ($urandom_range(0, 3) == 0) write_setting(REG_STATIC_COLOR, 24'($urandom));
	endtask

	initial begin
		int items_done;
		int n;
		int waited;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset state, static colour and brightness extremes
		send_tick(1'b0);
		send_tick(1'b1);
		write_setting(REG_STATIC_COLOR, 24'hFFFFFF);
		write_setting(REG_WHITE_LEVEL, 24'hFFFFFF);
		send_tick(1'b1);
		write_setting(REG_BRIGHTNESS, 24'h000000);
		send_tick(1'b0);
		write_setting(REG_STATIC_COLOR, 24'h000000);
		write_setting(REG_BRIGHTNESS, 24'hABCDFF);
		send_tick(1'b1);

		// wheel runs into the top and turns back
		write_setting(REG_EFFECT_MODE, {21'd0, MODE_WHEEL});
		write_setting(REG_STEP_SIZE, 24'd255);
		repeat (7) send_tick(1'b1);

		// hue clamps at both ends
		write_setting(REG_EFFECT_MODE, {21'd0, MODE_HUE});
		repeat (3) send_tick(1'b1);

		// pastel with zero step, then a step past the top
		write_setting(REG_EFFECT_MODE, {21'd0, MODE_PASTEL});
		write_setting(REG_STEP_SIZE, 24'd0);
		send_tick(1'b1);
		write_setting(REG_STEP_SIZE, 24'd200);
		repeat (2) send_tick(1'b1);

		// strobe goes dark, holds its phase without advance and lights again, other modes ignore it
		write_setting(REG_EFFECT_MODE, {21'd0, MODE_STROBE});
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		write_setting(REG_EFFECT_MODE, {21'd0, MODE_SPARE});
		send_tick(1'b1);
		write_setting(REG_SPARE, 24'h5A5A5A);
		send_tick(1'b0);

		items_done = 0;
		while (items_done < RAND_ITEMS) begin
			random_settings();
			n = $urandom_range(4, 30);
			repeat (n) begin
				calm = (items_done >= 250 && items_done < 400);
				send_tick($urandom_range(0, 99) < 80);
				items_done++;
			end
		end
		calm = 1'b0;

		@(negedge clk);
		in_valid = 1'b0;
		waited = 0;
		while (sb.pending_duties.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (sb.pending_duties.size() != 0) begin
			$display("%0t: %0d items never came out", $time, sb.pending_duties.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("PASS rgbw_led_effect_engine");
		end else begin
			$display("FAIL rgbw_led_effect_engine");
		end
		$finish;
	end

endmodule
